[design/fpa_pkg.sv]
// Shared types and constants for the single-precision adder pipeline.
`default_nettype none
package fpa_pkg;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned Ext   = 31;
  localparam int unsigned Top   = FracW + Ext;   // 54
  localparam int unsigned MW    = Top + 2;       // 56-bit working sum
  localparam logic [FracW-1:0] QuietBit = 23'h400000;
  localparam logic [FracW-1:0] FracMask = 23'h7fffff;
  localparam logic [ExpW-1:0]  ExpMax   = 8'hff;

  // Special-case result carried alongside the datapath
  typedef struct packed {
    logic             hit;
    logic             s;
    logic [ExpW-1:0]  e;
    logic [FracW-1:0] f;
  } spec_t;

  // After operand ordering
  typedef struct packed {
    spec_t            sp;
    logic             bigs;
    logic             sub;
    logic [ExpW-1:0]  bige;
    logic [ExpW-1:0]  d;
    logic [FracW:0]   bigm;
    logic [FracW:0]   smlm;
  } ord_t;

  // After align and add
  typedef struct packed {
    spec_t           sp;
    logic            rs;
    logic [ExpW-1:0] bige;
    logic [MW-1:0]   m;
  } sum_t;

  // After leading-one search
  typedef struct packed {
    spec_t           sp;
    logic            rs;
    logic [ExpW-1:0] bige;
    logic [MW-1:0]   m;
    logic [5:0]      p;
    logic            zero;
  } lzc_t;
endpackage
`default_nettype wire

[design/fpa_order.sv]
// Stage 1: special cases, operand ordering, exponent difference.
`default_nettype none
module fpa_order (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire logic [63:0]  data_i,
  output logic              valid_o,
  output fpa_pkg::ord_t     ord_o
);
  import fpa_pkg::*;

  logic             as, bs;
  logic [ExpW-1:0]  ae, be;
  logic [FracW-1:0] af, bf;
  logic             a_big;
  ord_t             ord_d, ord_q;
  logic             valid_q;

  assign as = data_i[0];
  assign ae = data_i[8:1];
  assign af = data_i[31:9];
  assign bs = data_i[32];
  assign be = data_i[40:33];
  assign bf = data_i[63:41];
  assign a_big = (ae > be) || ((ae == be) && (af >= bf));

  always_comb begin
    ord_d = '0;
    // NaN, infinity, zero priority chain
    if (ae == ExpMax && af != '0) begin
      ord_d.sp = '{1'b1, as, ExpMax, af | QuietBit};
    end else if (be == ExpMax && bf != '0) begin
      ord_d.sp = '{1'b1, bs, ExpMax, bf | QuietBit};
    end else if (ae == ExpMax && be == ExpMax) begin
      if (as != bs) ord_d.sp = '{1'b1, 1'b0, ExpMax, QuietBit};
      else          ord_d.sp = '{1'b1, as, ExpMax, '0};
    end else if (ae == ExpMax) begin
      ord_d.sp = '{1'b1, as, ExpMax, '0};
    end else if (be == ExpMax) begin
      ord_d.sp = '{1'b1, bs, ExpMax, '0};
    end else if (ae == '0 && be == '0) begin
      ord_d.sp = '{1'b1, as & bs, '0, '0};
    end else if (ae == '0) begin
      ord_d.sp = '{1'b1, bs, be, bf};
    end else if (be == '0) begin
      ord_d.sp = '{1'b1, as, ae, af};
    end
    // larger magnitude first
    if (a_big) begin
      ord_d.bigs = as; ord_d.bige = ae; ord_d.d = ae - be;
      ord_d.bigm = {1'b1, af}; ord_d.smlm = {1'b1, bf};
    end else begin
      ord_d.bigs = bs; ord_d.bige = be; ord_d.d = be - ae;
      ord_d.bigm = {1'b1, bf}; ord_d.smlm = {1'b1, af};
    end
    ord_d.sub = as ^ bs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ord_q <= ord_d;
    end
  end

  assign valid_o = valid_q;
  assign ord_o   = ord_q;
endmodule
`default_nettype wire

[design/fpa_align.sv]
// Stage 2: align smaller significand with sticky bit, then add or subtract.
`default_nettype none
module fpa_align (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fpa_pkg::ord_t ord_i,
  output logic               valid_o,
  output fpa_pkg::sum_t      sum_o
);
  import fpa_pkg::*;

  logic [Top:0]  bigx, smlx, shifted, lostmask;
  logic [5:0]    sh;
  sum_t          sum_d, sum_q;
  logic          valid_q;

  assign bigx = {ord_i.bigm, {Ext{1'b0}}};
  assign sh   = ord_i.d[5:0];

  always_comb begin
    lostmask = ({{Top{1'b0}}, 1'b1} << sh) - {{Top{1'b0}}, 1'b1};
    shifted  = {ord_i.smlm, {Ext{1'b0}}} >> sh;
    // beyond the full width only a sticky bit survives
    if (ord_i.d > ExpW'(Top)) begin
      smlx = {{Top{1'b0}}, 1'b1};
    end else begin
      smlx = shifted | {{Top{1'b0}}, |({ord_i.smlm, {Ext{1'b0}}} & lostmask)};
    end
    sum_d.sp   = ord_i.sp;
    sum_d.rs   = ord_i.bigs;
    sum_d.bige = ord_i.bige;
    if (ord_i.sub) sum_d.m = {1'b0, bigx} - {1'b0, smlx};
    else           sum_d.m = {1'b0, bigx} + {1'b0, smlx};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
endmodule
`default_nettype wire

[design/fpa_lzc.sv]
// Stage 3: leading-one position of the raw sum.
`default_nettype none
module fpa_lzc (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fpa_pkg::sum_t sum_i,
  output logic               valid_o,
  output fpa_pkg::lzc_t      lzc_o
);
  import fpa_pkg::*;

  lzc_t lzc_d, lzc_q;
  logic valid_q;

  always_comb begin
    lzc_d.sp   = sum_i.sp;
    lzc_d.rs   = sum_i.rs;
    lzc_d.bige = sum_i.bige;
    lzc_d.m    = sum_i.m;
    lzc_d.zero = (sum_i.m == '0);
    lzc_d.p    = '0;
    // priority scan, lowest set bit overwritten by higher ones
    for (int i = 0; i < MW; i++) begin
      if (sum_i.m[i]) lzc_d.p = 6'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lzc_q <= lzc_d;
    end
  end

  assign valid_o = valid_q;
  assign lzc_o   = lzc_q;
endmodule
`default_nettype wire

[design/fp32_adder_core.sv]
// Top level: four-stage single-precision adder with truncation toward zero.
//
//  channel   dir  width  contents
//  s_axis    in   64     a_sign, a_exponent, a_fraction, b_sign, b_exponent, b_fraction
//  m_axis    out  32     sum_sign, sum_exponent, sum_fraction
//
// One item per cycle sustained while m_axis_tready stays high.
// Stages: order/special cases, align+add, leading-one search, normalize+pack.
// Reset clears only the valid bits of each stage.
// A stall at m_axis freezes every stage together; s_axis_tready follows it.
`default_nettype none
module fp32_adder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] a_sign, [8:1] a_exponent, [31:9] a_fraction,
  // [32] b_sign, [40:33] b_exponent, [63:41] b_fraction
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] sum_sign, [8:1] sum_exponent, [31:9] sum_fraction
  output logic [31:0]      m_axis_tdata
);
  import fpa_pkg::*;

  logic          en;
  logic          v1, v2, v3, out_valid_q;
  ord_t          ord;
  sum_t          sum;
  lzc_t          lzc;
  logic [MW-1:0] mn;
  logic signed [9:0] e;
  logic [31:0]   out_d, out_q;

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  fpa_order u_order (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .data_i(s_axis_tdata), .valid_o(v1), .ord_o(ord)
  );

  fpa_align u_align (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .ord_i(ord),
    .valid_o(v2), .sum_o(sum)
  );

  fpa_lzc u_lzc (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .sum_i(sum),
    .valid_o(v3), .lzc_o(lzc)
  );

  // Stage 4: normalize shift, exponent adjust, saturation, pack
  always_comb begin
    if (lzc.p > 6'(Top)) mn = lzc.m >> 1;
    else                 mn = lzc.m << (6'(Top) - lzc.p);
    e = $signed({2'b00, lzc.bige}) + $signed({4'b0000, lzc.p}) - 10'sd54;
    if (lzc.sp.hit) begin
      out_d = {lzc.sp.f, lzc.sp.e, lzc.sp.s};
    end else if (lzc.zero) begin
      out_d = '0;
    end else if (e >= 10'sd255) begin
      out_d = {{FracW{1'b0}}, ExpMax, lzc.rs};
    end else if (e <= 10'sd0) begin
      out_d = {{FracW{1'b0}}, {ExpW{1'b0}}, lzc.rs};
    end else begin
      out_d = {mn[Top-1:Ext] & FracMask, e[7:0], lzc.rs};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // flushed exponent never carries a fraction
  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8:1] == 8'h00 |-> m_axis_tdata[31:9] == '0)
    else $error("nonzero fraction with zero exponent");

  // accepted item reaches stage one
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted item lost at stage one");

  // ready exactly when the output stage can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready out of step with output stage");
endmodule
`default_nettype wire
